// File: design/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// shared types and constants for the frame receiver with checksum check
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  localparam logic [7:0]  SYNC0 = 8'hA0;
  localparam logic [7:0]  SYNC1 = 8'hA4;
  localparam logic [7:0]  FOOT0 = 8'hB0;
  localparam logic [7:0]  FOOT1 = 8'hB2;
  localparam logic [14:0] SUM_MASK = 15'h7FFF;
  localparam logic [1:0]  ENC_STUFFED = 2'd1;
  localparam int unsigned HDR_LEN = 4;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;
  localparam logic        UNSTUFF_RESET = 1'b0;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_UNSTUFF = 1'b1;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_FOOTER  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_HDR  = 6'b000100,
    PH_PAY  = 6'b001000,
    PH_CSUM = 6'b010000,
    PH_FTR  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [15:0] max_payload_len;
    logic        unstuff_enable;
  } cfg_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_kind;
    logic       frame_end;
    logic [1:0] frame_status;
    logic       in_sync;
  } result_t;

endpackage

`default_nettype wire

// File: design/frc_regs.sv
// ----------------------------------------------------------------------------
// frc_regs
// apb configuration registers: payload length limit and unstuff enable
// ----------------------------------------------------------------------------
`default_nettype none

module frc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [frc_pkg::APB_AW-1:0] paddr,
  input  wire logic [frc_pkg::APB_DW-1:0] pwdata,
  output logic      [frc_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output frc_pkg::cfg_t                   cfg
);
  import frc_pkg::*;

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload_len <= MAX_LEN_RESET;
      cfg.unstuff_enable  <= UNSTUFF_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_LEN: cfg.max_payload_len <= pwdata[15:0];
        REG_UNSTUFF: cfg.unstuff_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_LEN: prdata = {16'd0, cfg.max_payload_len};
      REG_UNSTUFF: prdata = {31'd0, cfg.unstuff_enable};
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/frc_in_stage.sv
// ----------------------------------------------------------------------------
// frc_in_stage
// input register for the received byte stream
// ----------------------------------------------------------------------------
`default_nettype none

module frc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            s1_valid,
  output logic [7:0]      s1_byte,
  input  wire logic       down_ready
);

  assign in_ready = !s1_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

// File: design/frc_parser.sv
// ----------------------------------------------------------------------------
// frc_parser
// frame state machine, checksum accumulation, unstuffing and result register
// ----------------------------------------------------------------------------
`default_nettype none

module frc_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire frc_pkg::cfg_t cfg,
  input  wire logic       s1_valid,
  input  wire logic [7:0] s1_byte,
  output logic            down_ready,
  output logic            res_valid,
  input  wire logic       res_ready,
  output frc_pkg::result_t res
);
  import frc_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] step_count, step_count_next;
  logic [15:0] payload_length, payload_length_next;
  logic [14:0] sum_acc, sum_acc_next;
  logic [15:0] rx_sum, rx_sum_next;
  logic [1:0]  encoding_field, encoding_field_next;
  logic        last_was_a0, last_was_a0_next;
  result_t     res_next;
  logic        take;
  logic [16:0] step_inc;
  logic [14:0] sum_add;
  logic [15:0] len_shift;
  logic        drop;

  assign down_ready = !res_valid || res_ready;
  assign take       = s1_valid && down_ready;
  assign step_inc   = {1'b0, step_count} + 17'd1;
  assign sum_add    = (sum_acc + {7'd0, s1_byte}) & SUM_MASK;
  assign len_shift  = {payload_length[7:0], s1_byte};
  assign drop       = cfg.unstuff_enable && (encoding_field == ENC_STUFFED)
                      && last_was_a0 && (s1_byte == 8'd0);

  always_comb begin
    phase_next          = phase;
    step_count_next     = step_count;
    payload_length_next = payload_length;
    sum_acc_next        = sum_acc;
    rx_sum_next         = rx_sum;
    encoding_field_next = encoding_field;
    last_was_a0_next    = last_was_a0;
    res_next            = '0;
    res_next.in_sync    = (phase != PH_HUNT);

    unique case (phase)
      PH_LEN: begin
        payload_length_next = len_shift;
        step_count_next     = step_inc[15:0];
        if (step_inc >= 17'd2) begin
          step_count_next = '0;
          if (len_shift > cfg.max_payload_len) begin
            res_next.frame_end    = 1'b1;
            res_next.frame_status = ST_TOO_LONG;
            phase_next            = PH_HUNT;
          end else begin
            phase_next   = PH_HDR;
            sum_acc_next = '0;
          end
        end
      end
      PH_HDR: begin
        res_next.out_valid = 1'b1;
        res_next.out_byte  = s1_byte;
        res_next.out_kind  = 1'b0;
        if (step_count == 16'd0) begin
          encoding_field_next = s1_byte[3:2];
        end
        sum_acc_next    = sum_add;
        step_count_next = step_inc[15:0];
        if (step_inc >= 17'(HDR_LEN)) begin
          step_count_next  = '0;
          last_was_a0_next = 1'b0;
          phase_next       = (payload_length != 16'd0) ? PH_PAY : PH_CSUM;
        end
      end
      PH_PAY: begin
        sum_acc_next = sum_add;
        if (drop) begin
          last_was_a0_next = 1'b0;
        end else begin
          res_next.out_valid = 1'b1;
          res_next.out_byte  = s1_byte;
          res_next.out_kind  = 1'b1;
          last_was_a0_next   = (s1_byte == SYNC0);
        end
        step_count_next = step_inc[15:0];
        if (step_inc >= {1'b0, payload_length}) begin
          step_count_next = '0;
          phase_next      = PH_CSUM;
        end
      end
      PH_CSUM: begin
        rx_sum_next     = {rx_sum[7:0], s1_byte};
        step_count_next = step_inc[15:0];
        if (step_inc >= 17'd2) begin
          step_count_next = '0;
          phase_next      = PH_FTR;
        end
      end
      PH_FTR: begin
        if (step_count == 16'd0 && s1_byte == FOOT0) begin
          step_count_next = 16'd1;
        end else if (step_count == 16'd1 && s1_byte == FOOT1) begin
          res_next.frame_end    = 1'b1;
          res_next.frame_status = (rx_sum == {1'b0, sum_acc}) ? ST_GOOD : ST_CSUM;
          phase_next            = PH_HUNT;
          step_count_next       = '0;
        end else begin
          res_next.frame_end    = 1'b1;
          res_next.frame_status = ST_FOOTER;
          phase_next            = PH_HUNT;
          step_count_next       = '0;
        end
      end
      default: begin
        // sync hunt: step_count holds 1 after an a0
        if (step_count == 16'd1 && s1_byte == SYNC1) begin
          phase_next          = PH_LEN;
          step_count_next     = '0;
          payload_length_next = '0;
          rx_sum_next         = '0;
          sum_acc_next        = '0;
        end else begin
          phase_next      = PH_HUNT;
          step_count_next = (s1_byte == SYNC0) ? 16'd1 : 16'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      step_count     <= '0;
      payload_length <= '0;
      sum_acc        <= '0;
      rx_sum         <= '0;
      encoding_field <= '0;
      last_was_a0    <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (take) begin
        phase          <= phase_next;
        step_count     <= step_count_next;
        payload_length <= payload_length_next;
        sum_acc        <= sum_acc_next;
        rx_sum         <= rx_sum_next;
        encoding_field <= encoding_field_next;
        last_was_a0    <= last_was_a0_next;
      end
      if (down_ready) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: design/frame_receiver_checksum_check.sv
// ----------------------------------------------------------------------------
// frame_receiver_checksum_check
// Takes one received byte per cycle, while res_ready holds, on the
// in_valid/in_ready channel and gives exactly one result word per byte on the
// res_valid/res_ready channel, through an input register, the single-pass
// frame parser (sync hunt, length, header, payload, checksum, footer) and a
// result register. A low res_ready stalls the result register and backs up
// to in_ready. The parser state updates once per byte, which sets that rate.
// Header and payload bytes stream out flagged by out_valid/out_kind;
// frame_end with frame_status closes every frame. Configure through the apb
// port (0x0 max_payload_len, 0x4 unstuff_enable) only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_receiver_checksum_check (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [frc_pkg::APB_AW-1:0] paddr,
  input  wire logic [frc_pkg::APB_DW-1:0] pwdata,
  output logic      [frc_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_byte,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output logic                            out_valid,
  output logic [7:0]                      out_byte,
  output logic                            out_kind,
  output logic                            frame_end,
  output logic [1:0]                      frame_status,
  output logic                            in_sync
);
  import frc_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       down_ready;

  frc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte),
    .down_ready (down_ready)
  );

  frc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte),
    .down_ready (down_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign out_valid    = res.out_valid;
  assign out_byte     = res.out_byte;
  assign out_kind     = res.out_kind;
  assign frame_end    = res.frame_end;
  assign frame_status = res.frame_status;
  assign in_sync      = res.in_sync;

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the frame receiver with checksum check. It sends a serial
// byte stream of short hand-built frames and then random frames. The random
// frames mix good frames, checksum errors, bad footers, over-length frames,
// cut-off frames and noise. The block runs under a series of max length and
// unstuffing settings. A scoreboard class tracks the parser state byte by
// byte and checks every result word in order. Both handshakes stall at
// random, and once the result side holds off long enough to back up the
// input side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frc_pkg::*;

  typedef enum int {FLT_NONE, FLT_CSUM, FLT_FOOT0, FLT_FOOT1, FLT_TRUNC} fault_t;

  class frame_parse_model;
    result_t     pending_words[$];
    int          n_bad;
    phase_t      ph;
    logic [15:0] cnt;
    logic [15:0] plen;
    logic [14:0] acc;
    logic [15:0] rx_csum;
    logic [1:0]  enc;
    logic        after_a0;
    logic [15:0] max_len;
    logic        unstuff_on;

    function new();
      n_bad      = 0;
      ph         = PH_HUNT;
      cnt        = '0;
      plen       = '0;
      acc        = '0;
      rx_csum    = '0;
      enc        = '0;
      after_a0   = 1'b0;
      max_len    = MAX_LEN_RESET;
      unstuff_on = UNSTUFF_RESET;
    endfunction

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == REG_MAX_LEN) begin
        max_len = value;
      end else begin
        unstuff_on = value[0];
      end
    endfunction

    function result_t parse_byte(logic [7:0] b);
      result_t r;
      r = '0;
      r.in_sync = (ph != PH_HUNT);
      case (ph)
        PH_LEN: begin
          plen = {plen[7:0], b};
          cnt  = cnt + 16'd1;
          if (cnt >= 16'd2) begin
            if (plen > max_len) begin
              r.frame_end    = 1'b1;
              r.frame_status = ST_TOO_LONG;
              ph  = PH_HUNT;
              cnt = '0;
            end else begin
              ph  = PH_HDR;
              cnt = '0;
              acc = '0;
            end
          end
        end
        PH_HDR: begin
          r.out_valid = 1'b1;
          r.out_byte  = b;
          if (cnt == 16'd0) enc = b[3:2];
          acc = acc + b;
          cnt = cnt + 16'd1;
          if (cnt >= 16'(HDR_LEN)) begin
            cnt      = '0;
            after_a0 = 1'b0;
            ph       = (plen > 16'd0) ? PH_PAY : PH_CSUM;
          end
        end
        PH_PAY: begin
          acc = acc + b;
          if (unstuff_on && enc == ENC_STUFFED && after_a0 && b == 8'h00) begin
            after_a0 = 1'b0;
          end else begin
            r.out_valid = 1'b1;
            r.out_byte  = b;
            r.out_kind  = 1'b1;
            after_a0    = (b == SYNC0);
          end
          cnt = cnt + 16'd1;
          if (cnt >= plen) begin
            cnt = '0;
            ph  = PH_CSUM;
          end
        end
        PH_CSUM: begin
          rx_csum = {rx_csum[7:0], b};
          cnt     = cnt + 16'd1;
          if (cnt >= 16'd2) begin
            cnt = '0;
            ph  = PH_FTR;
          end
        end
        PH_FTR: begin
          if (cnt == 16'd0 && b == FOOT0) begin
            cnt = 16'd1;
          end else if (cnt == 16'd1 && b == FOOT1) begin
            r.frame_end    = 1'b1;
            r.frame_status = (rx_csum == {1'b0, acc}) ? ST_GOOD : ST_CSUM;
            ph  = PH_HUNT;
            cnt = '0;
          end else begin
            r.frame_end    = 1'b1;
            r.frame_status = ST_FOOTER;
            ph  = PH_HUNT;
            cnt = '0;
          end
        end
        default: begin
          if (ph != PH_HUNT || cnt > 16'd1) begin
            ph  = PH_HUNT;
            cnt = '0;
          end
          if (cnt == 16'd1 && b == SYNC1) begin
            ph      = PH_LEN;
            cnt     = '0;
            plen    = '0;
            rx_csum = '0;
            acc     = '0;
          end else begin
            cnt = (b == SYNC0) ? 16'd1 : 16'd0;
          end
        end
      endcase
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      pending_words.push_back(parse_byte(b));
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        n_bad++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        $error("result word with no byte outstanding");
        n_bad++;
        return;
      end
      want = pending_words.pop_front();
      check_field("out_valid", want.out_valid, got.out_valid);
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("out_kind", want.out_kind, got.out_kind);
      check_field("frame_end", want.frame_end, got.frame_end);
      check_field("frame_status", want.frame_status, got.frame_status);
      check_field("in_sync", want.in_sync, got.in_sync);
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_kind;
  logic               frame_end;
  logic [1:0]         frame_status;
  logic               in_sync;

  frame_parse_model model = new();
  logic [7:0]       tx_bytes[$];
  logic [7:0]       frame_body[$];
  int               n_sent = 0;
  bit               steady = 1'b0;
  bit               hold_req = 1'b0;

  frame_receiver_checksum_check u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .frame_end    (frame_end),
    .frame_status (frame_status),
    .in_sync      (in_sync)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      model.check_word({out_valid, out_byte, out_kind, frame_end, frame_status, in_sync});
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        res_ready <= steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  task automatic reg_write(logic idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model.set_reg(idx, value);
  endtask

  task automatic send_byte(logic [7:0] b);
    if (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    model.note_byte(b);
    n_sent++;
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return SYNC0;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // sync, length, body, checksum and footer, with an optional fault
  function automatic void wrap_frame(fault_t fault);
    logic [15:0] len;
    logic [15:0] sum;
    logic [7:0]  f0;
    logic [7:0]  f1;
    len = 16'(frame_body.size() - HDR_LEN);
    sum = '0;
    foreach (frame_body[i]) sum = (sum + frame_body[i]) & {1'b0, SUM_MASK};
    if (fault == FLT_CSUM) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    f0 = FOOT0;
    f1 = FOOT1;
    if (fault == FLT_FOOT0) f0 = FOOT0 ^ 8'($urandom_range(1, 255));
    if (fault == FLT_FOOT1) f1 = FOOT1 ^ 8'($urandom_range(1, 255));
    tx_bytes = {tx_bytes, SYNC0, SYNC1, len[15:8], len[7:0]};
    tx_bytes = {tx_bytes, frame_body};
    tx_bytes = {tx_bytes, sum[15:8], sum[7:0], f0, f1};
    if (fault == FLT_TRUNC) begin
      repeat ($urandom_range(1, 3)) void'(tx_bytes.pop_back());
    end
    frame_body.delete();
  endfunction

  function automatic void rand_frame(int n);
    logic [7:0] h0;
    int         roll;
    fault_t     fault;
    h0 = 8'($urandom);
    if ($urandom_range(0, 1) == 1) h0[3:2] = ENC_STUFFED;
    frame_body.push_back(h0);
    repeat (HDR_LEN - 1) frame_body.push_back(pick_byte());
    repeat (n) frame_body.push_back(pick_byte());
    roll = $urandom_range(0, 99);
    if (roll < 65)      fault = FLT_NONE;
    else if (roll < 75) fault = FLT_CSUM;
    else if (roll < 83) fault = FLT_FOOT0;
    else if (roll < 91) fault = FLT_FOOT1;
    else                fault = FLT_TRUNC;
    wrap_frame(fault);
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(0, 3)) tx_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      tx_bytes.push_back(SYNC0);
      tx_bytes.push_back(SYNC1 ^ 8'($urandom_range(1, 255)));
    end
  endfunction

  task automatic run_random(int target, int max_pay, int big_pay, bit len_only);
    logic [15:0] len;
    int          stop;
    stop = n_sent + target;
    while (n_sent < stop) begin
      add_noise();
      if (len_only && $urandom_range(0, 2) == 0) begin
        len = 16'($urandom);
        tx_bytes = {tx_bytes, SYNC0, SYNC1, len[15:8], len[7:0]};
      end else if ($urandom_range(0, 39) == 0) begin
        rand_frame($urandom_range(big_pay - 1, big_pay));
      end else begin
        rand_frame($urandom_range(0, max_pay));
      end
      send_queued();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    reg_write(REG_MAX_LEN, 16'hFFFF);
    reg_write(REG_UNSTUFF, 16'd1);
    // broken sync, repeated first sync byte, stuffed header and payload
    tx_bytes = {SYNC0, 8'h55, SYNC0, SYNC0};
    frame_body = {8'h04, SYNC0, 8'h00, 8'hFF, SYNC0, 8'h00, 8'h00};
    wrap_frame(FLT_NONE);
    // empty payload, bad first footer byte
    frame_body = {8'h7F, 8'h80, 8'h01, 8'hFE};
    wrap_frame(FLT_FOOT0);
    send_queued();
    run_random(330, 12, 40, 1'b0);

    reg_write(REG_MAX_LEN, 16'd0);
    reg_write(REG_UNSTUFF, 16'd0);
    run_random(300, 6, 10, 1'b1);

    reg_write(REG_MAX_LEN, 16'd10);
    reg_write(REG_UNSTUFF, 16'd1);
    hold_req = 1'b1;
    run_random(400, 14, 20, 1'b1);

    reg_write(REG_MAX_LEN, 16'd300);
    reg_write(REG_UNSTUFF, 16'd0);
    steady = 1'b1;
    run_random(420, 16, 301, 1'b0);
    steady = 1'b0;

    reg_write(REG_MAX_LEN, 16'hFFFF);
    reg_write(REG_UNSTUFF, 16'd1);
    run_random(400, 20, 500, 1'b1);

    repeat (6) @(posedge clk);
    if (model.n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
